/* hdl/ppp_pkg.sv */
// Shared types and constants of the perspective point projector.
`default_nettype none
package ppp_pkg;

  // Default fraction bits of world coordinates
  localparam int DEF_COORD_FRAC_BITS = 16;

  // Datapath widths fixed by the field formats
  localparam int COORD_W  = 32;
  localparam int TRIG_W   = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = DIFF_W + TRIG_W;
  localparam int ROT_W    = PROD_W + 1;
  localparam int TRIG_FRAC = 14;
  localparam int PD_W     = 31;
  localparam int SIZE_W   = 13;
  localparam int SCALE_W  = SIZE_W - 2;
  localparam int CEN_W    = SIZE_W - 1;
  localparam int PDK_W    = PD_W + SCALE_W;
  localparam int PIX_W    = 16;
  localparam int QUO_W    = PIX_W + 1;
  localparam int DIV_LAT  = QUO_W;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_CAMERA_X      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CAMERA_Y      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAMERA_Z      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_YAW_COS       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_YAW_SIN       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_DIST    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd7;

  // Register reset values
  localparam logic [COORD_W-1:0] RST_CAMERA_X = 32'hFFFB_0000;
  localparam logic [COORD_W-1:0] RST_CAMERA_Y = 32'h0000_0000;
  localparam logic [COORD_W-1:0] RST_CAMERA_Z = 32'h0000_0000;
  localparam logic [TRIG_W-1:0]  RST_YAW_COS  = 16'h4000;
  localparam logic [TRIG_W-1:0]  RST_YAW_SIN  = 16'h0000;
  localparam logic [PD_W-1:0]    RST_PLANE_DIST = 31'd196608;
  localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = 13'd1200;
  localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = 13'd800;

  // Rotated point handed from the front end to the projection back end
  typedef struct packed {
    logic signed [ROT_W-1:0] rx;
    logic signed [ROT_W-1:0] ry;
    logic signed [ROT_W-1:0] rz;
    logic                    behind;
  } rot_item_t;

  // Per-item flags that ride alongside the dividers
  typedef struct packed {
    logic zero;
    logic behind;
    logic neg_col;
    logic neg_row;
  } proj_flags_t;

endpackage
`default_nettype wire

/* hdl/ppp_front.sv */
// Front end: camera offset, yaw rotation and depth classification.
`default_nettype none
module ppp_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] point_x,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] point_y,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] point_z,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] camera_x,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] camera_y,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] camera_z,
  input  wire logic signed [ppp_pkg::TRIG_W-1:0]  yaw_cos,
  input  wire logic signed [ppp_pkg::TRIG_W-1:0]  yaw_sin,
  output logic                                    out_valid,
  output ppp_pkg::rot_item_t                      out_item
);

  logic                                   v1, v2;
  logic signed [ppp_pkg::DIFF_W-1:0]      dx, dy, dz;
  logic signed [ppp_pkg::PROD_W-1:0]      pcx, psy, pcy, psx;
  logic signed [ppp_pkg::DIFF_W-1:0]      dz2;
  logic signed [ppp_pkg::ROT_W-1:0]       rx_sum, ry_sum;

  // Valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Subtract the camera position
  always_ff @(posedge clk) begin
    dx <= ppp_pkg::DIFF_W'(point_x) - ppp_pkg::DIFF_W'(camera_x);
    dy <= ppp_pkg::DIFF_W'(point_y) - ppp_pkg::DIFF_W'(camera_y);
    dz <= ppp_pkg::DIFF_W'(point_z) - ppp_pkg::DIFF_W'(camera_z);
  end

  // Form the rotation products
  always_ff @(posedge clk) begin
    pcx <= yaw_cos * dx;
    psy <= yaw_sin * dy;
    pcy <= yaw_cos * dy;
    psx <= yaw_sin * dx;
    dz2 <= dz;
  end

  // Combine into depth, lateral and vertical
  assign rx_sum = ppp_pkg::ROT_W'(pcx) + ppp_pkg::ROT_W'(psy);
  assign ry_sum = ppp_pkg::ROT_W'(pcy) - ppp_pkg::ROT_W'(psx);

  always_ff @(posedge clk) begin
    out_item.rx     <= rx_sum;
    out_item.ry     <= ry_sum;
    out_item.rz     <= ppp_pkg::ROT_W'(dz2) <<< ppp_pkg::TRIG_FRAC;
    out_item.behind <= rx_sum[ppp_pkg::ROT_W-1] || (rx_sum == '0);
  end

endmodule
`default_nettype wire

/* hdl/ppp_queue.sv */
// Short request queue between the front end and the projection back end.
`default_nettype none
module ppp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ppp_pkg::rot_item_t push_item,
  output logic                    full,
  output logic                    out_valid,
  output ppp_pkg::rot_item_t      out_item
);

  localparam int PTR_W = (ppp_pkg::QUEUE_DEPTH > 1) ? $clog2(ppp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ppp_pkg::QUEUE_DEPTH + 1);

  ppp_pkg::rot_item_t mem [0:ppp_pkg::QUEUE_DEPTH-1];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;

  // Back end takes a request every cycle one is waiting
  assign pop       = (count != '0);
  assign out_valid = pop;
  assign out_item  = mem[rd_ptr];
  assign full      = (count == CNT_W'(ppp_pkg::QUEUE_DEPTH));

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(ppp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(ppp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/ppp_divider.sv */
// Pipelined restoring divider, quotient clamped to 2^16, one bit per stage.
`default_nettype none
module ppp_divider #(
  parameter int COORD_FRAC_BITS = ppp_pkg::DEF_COORD_FRAC_BITS,
  parameter int NUM_W           = 93
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [NUM_W-1:0]              num,
  input  wire logic [ppp_pkg::ROT_W-1:0]     den,
  output logic                               out_valid,
  output logic [ppp_pkg::QUO_W-1:0]          quo
);

  localparam int LAT = ppp_pkg::DIV_LAT;
  localparam int QB  = ppp_pkg::QUO_W - 1;

  logic [NUM_W-1:0]          rem  [0:LAT-1];
  logic [ppp_pkg::ROT_W-1:0] dv   [0:LAT-1];
  logic [ppp_pkg::QUO_W-1:0] qv   [0:LAT-1];
  logic                      done [0:LAT-1];
  logic                      vl   [0:LAT-1];
  logic [NUM_W-1:0]          lim;

  assign lim = NUM_W'(den) << (COORD_FRAC_BITS + QB);

  // Clamp check
  always_ff @(posedge clk) begin
    rem[0]  <= num;
    dv[0]   <= den;
    done[0] <= (num >= lim);
    qv[0]   <= (num >= lim) ? ppp_pkg::QUO_W'(1) << QB : '0;
  end

  // One quotient bit per stage
  for (genvar j = 1; j < LAT; j++) begin : g_step
    logic [NUM_W-1:0] trial;
    assign trial = NUM_W'(dv[j-1]) << (COORD_FRAC_BITS + QB - j);
    always_ff @(posedge clk) begin
      dv[j]   <= dv[j-1];
      done[j] <= done[j-1];
      if (!done[j-1] && rem[j-1] >= trial) begin
        rem[j] <= rem[j-1] - trial;
        qv[j]  <= qv[j-1] | (ppp_pkg::QUO_W'(1) << (QB - j));
      end else begin
        rem[j] <= rem[j-1];
        qv[j]  <= qv[j-1];
      end
    end
  end

  // Valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        vl[k] <= 1'b0;
      end
    end else begin
      vl[0] <= in_valid;
      for (int k = 1; k < LAT; k++) begin
        vl[k] <= vl[k-1];
      end
    end
  end

  assign out_valid = vl[LAT-1];
  assign quo       = qv[LAT-1];

endmodule
`default_nettype wire

/* hdl/ppp_back.sv */
// Back end: scale, add center, divide by depth and saturate.
`default_nettype none
module ppp_back #(
  parameter int COORD_FRAC_BITS = ppp_pkg::DEF_COORD_FRAC_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  input  wire ppp_pkg::rot_item_t                 in_item,
  input  wire logic [ppp_pkg::PDK_W-1:0]          pdk,
  input  wire logic [ppp_pkg::CEN_W-1:0]          cen_col,
  input  wire logic [ppp_pkg::CEN_W-1:0]          cen_row,
  output logic                                    out_valid,
  output logic signed [ppp_pkg::PIX_W-1:0]        pixel_column,
  output logic signed [ppp_pkg::PIX_W-1:0]        pixel_row,
  output logic                                    behind_camera
);

  localparam int RW   = ppp_pkg::ROT_W;
  localparam int ML   = RW / 2;
  localparam int MH   = RW - ML;
  localparam int PL   = ppp_pkg::PDK_W / 2;
  localparam int PH   = ppp_pkg::PDK_W - PL;
  localparam int PPW  = MH + PH;
  localparam int AW   = RW + ppp_pkg::PDK_W;
  localparam int CBPW = RW + ppp_pkg::CEN_W;
  localparam int CBW  = CBPW + COORD_FRAC_BITS;
  localparam int NW   = ((AW > CBW) ? AW : CBW) + 1;
  localparam int LAT  = ppp_pkg::DIV_LAT;

  // Stage 1: magnitudes and signs
  logic                 v1;
  logic [RW-1:0]        mrx1, mry1, mrz1;
  ppp_pkg::proj_flags_t f1;

  always_ff @(posedge clk) begin
    mrx1 <= in_item.rx[RW-1] ? RW'(-in_item.rx) : RW'(in_item.rx);
    mry1 <= in_item.ry[RW-1] ? RW'(-in_item.ry) : RW'(in_item.ry);
    mrz1 <= in_item.rz[RW-1] ? RW'(-in_item.rz) : RW'(in_item.rz);
    f1.zero    <= (in_item.rx == '0);
    f1.behind  <= in_item.behind;
    f1.neg_col <= in_item.ry[RW-1] ^ in_item.rx[RW-1];
    f1.neg_row <= in_item.rz[RW-1] ^ in_item.rx[RW-1];
  end

  // Stage 2: partial products and center terms
  logic                 v2;
  logic [RW-1:0]        mrx2;
  ppp_pkg::proj_flags_t f2;
  logic [PPW-1:0]       cll, clh, chl, chh, rll, rlh, rhl, rhh;
  logic [CBPW-1:0]      cbc2, cbr2;

  always_ff @(posedge clk) begin
    cll  <= PPW'(mry1[ML-1:0]  * pdk[PL-1:0]);
    clh  <= PPW'(mry1[ML-1:0]  * pdk[ppp_pkg::PDK_W-1:PL]);
    chl  <= PPW'(mry1[RW-1:ML] * pdk[PL-1:0]);
    chh  <= PPW'(mry1[RW-1:ML] * pdk[ppp_pkg::PDK_W-1:PL]);
    rll  <= PPW'(mrz1[ML-1:0]  * pdk[PL-1:0]);
    rlh  <= PPW'(mrz1[ML-1:0]  * pdk[ppp_pkg::PDK_W-1:PL]);
    rhl  <= PPW'(mrz1[RW-1:ML] * pdk[PL-1:0]);
    rhh  <= PPW'(mrz1[RW-1:ML] * pdk[ppp_pkg::PDK_W-1:PL]);
    cbc2 <= CBPW'(mrx1 * cen_col);
    cbr2 <= CBPW'(mrx1 * cen_row);
    mrx2 <= mrx1;
    f2   <= f1;
  end

  // Stage 3: sum partial products
  logic                 v3;
  logic [RW-1:0]        mrx3;
  ppp_pkg::proj_flags_t f3;
  logic [AW-1:0]        acol3, arow3;
  logic [CBW-1:0]       cbc3, cbr3;

  always_ff @(posedge clk) begin
    acol3 <= (AW'(chh) << (ML + PL)) + (AW'(chl) << ML) + (AW'(clh) << PL) + AW'(cll);
    arow3 <= (AW'(rhh) << (ML + PL)) + (AW'(rhl) << ML) + (AW'(rlh) << PL) + AW'(rll);
    cbc3  <= CBW'(cbc2) << COORD_FRAC_BITS;
    cbr3  <= CBW'(cbr2) << COORD_FRAC_BITS;
    mrx3  <= mrx2;
    f3    <= f2;
  end

  // Stage 4: signed offset by the center; neg flags become result signs
  logic                 v4;
  logic [RW-1:0]        mrx4;
  ppp_pkg::proj_flags_t f4;
  logic [NW-1:0]        ncol4, nrow4;
  logic                 sgn_col, sgn_row;
  logic [NW-1:0]        ncol_next, nrow_next;

  always_comb begin
    sgn_col = 1'b0;
    if (!f3.neg_col) begin
      ncol_next = NW'(acol3) + NW'(cbc3);
    end else if (NW'(cbc3) >= NW'(acol3)) begin
      ncol_next = NW'(cbc3) - NW'(acol3);
    end else begin
      ncol_next = NW'(acol3) - NW'(cbc3);
      sgn_col   = 1'b1;
    end
    sgn_row = 1'b0;
    if (!f3.neg_row) begin
      nrow_next = NW'(arow3) + NW'(cbr3);
    end else if (NW'(cbr3) >= NW'(arow3)) begin
      nrow_next = NW'(cbr3) - NW'(arow3);
    end else begin
      nrow_next = NW'(arow3) - NW'(cbr3);
      sgn_row   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ncol4      <= ncol_next;
    nrow4      <= nrow_next;
    mrx4       <= mrx3;
    f4.zero    <= f3.zero;
    f4.behind  <= f3.behind;
    f4.neg_col <= sgn_col;
    f4.neg_row <= sgn_row;
  end

  // Valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Dividers
  logic                      dv_col, dv_row;
  logic [ppp_pkg::QUO_W-1:0] qcol, qrow;

  ppp_divider #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .NUM_W(NW)) u_div_col (
    .clk(clk), .rst(rst), .in_valid(v4), .num(ncol4), .den(mrx4),
    .out_valid(dv_col), .quo(qcol)
  );

  ppp_divider #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .NUM_W(NW)) u_div_row (
    .clk(clk), .rst(rst), .in_valid(v4), .num(nrow4), .den(mrx4),
    .out_valid(dv_row), .quo(qrow)
  );

  // Carry flags alongside the dividers
  ppp_pkg::proj_flags_t fl [0:LAT-1];

  always_ff @(posedge clk) begin
    fl[0] <= f4;
    for (int k = 1; k < LAT; k++) begin
      fl[k] <= fl[k-1];
    end
  end

  // Apply sign and saturate
  function automatic logic [ppp_pkg::PIX_W-1:0] sat_pix(
    input logic [ppp_pkg::QUO_W-1:0] q,
    input logic                      neg
  );
    logic [ppp_pkg::QUO_W-1:0] nq;
    nq = -q;
    if (neg) begin
      sat_pix = (q > ppp_pkg::QUO_W'(32768)) ? 16'h8000 : nq[ppp_pkg::PIX_W-1:0];
    end else begin
      sat_pix = (q > ppp_pkg::QUO_W'(32767)) ? 16'h7FFF : q[ppp_pkg::PIX_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_col && dv_row;
    end
  end

  always_ff @(posedge clk) begin
    pixel_column  <= fl[LAT-1].zero ? '0 : sat_pix(qcol, fl[LAT-1].neg_col);
    pixel_row     <= fl[LAT-1].zero ? '0 : sat_pix(qrow, fl[LAT-1].neg_row);
    behind_camera <= fl[LAT-1].behind;
  end

endmodule
`default_nettype wire

/* hdl/perspective_point_projector.sv */
// Top level of the perspective point projector: registers, front, queue, back.
//
// A point request (point_x/y/z, signed fixed point) is taken at a rising edge
// where start is high and busy is low. The camera position is subtracted, the
// offset is rotated by minus the yaw, and the lateral and vertical components
// are divided by depth, scaled by plane_distance * floor(frame height/4) and
// offset by the image center. Each result appears on pixel_column, pixel_row
// and behind_camera for exactly one cycle with result_valid high.
// Path: 3 front stages, the queue memory, 4 scaling stages, 17 divider
// stages and an output register. One request is taken every cycle while busy
// is low; the 17-stage divider pipelines, one quotient bit per stage.
// The receiver cannot stall; the back end drains the queue every cycle, so
// busy stays low in normal use.
// Users write registers (wr_en/wr_index/wr_data) only with no request in flight,
// unenforced by the block. Reset clears pipelines, loads default camera setup.
`default_nettype none
module perspective_point_projector #(
  parameter int COORD_FRAC_BITS = ppp_pkg::DEF_COORD_FRAC_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [ppp_pkg::COORD_W-1:0]  point_x,
  input  wire logic signed [ppp_pkg::COORD_W-1:0]  point_y,
  input  wire logic signed [ppp_pkg::COORD_W-1:0]  point_z,
  output logic                                     result_valid,
  output logic signed [ppp_pkg::PIX_W-1:0]         pixel_column,
  output logic signed [ppp_pkg::PIX_W-1:0]         pixel_row,
  output logic                                     behind_camera,
  input  wire logic                                wr_en,
  input  wire logic [ppp_pkg::REG_IDX_W-1:0]       wr_index,
  input  wire logic [ppp_pkg::COORD_W-1:0]         wr_data
);

  logic signed [ppp_pkg::COORD_W-1:0] camera_x, camera_y, camera_z;
  logic signed [ppp_pkg::TRIG_W-1:0]  yaw_cos, yaw_sin;
  logic [ppp_pkg::PD_W-1:0]           plane_distance;
  logic [ppp_pkg::SIZE_W-1:0]         frame_width, frame_height;
  logic [ppp_pkg::PDK_W-1:0]          pdk;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x       <= ppp_pkg::RST_CAMERA_X;
      camera_y       <= ppp_pkg::RST_CAMERA_Y;
      camera_z       <= ppp_pkg::RST_CAMERA_Z;
      yaw_cos        <= ppp_pkg::RST_YAW_COS;
      yaw_sin        <= ppp_pkg::RST_YAW_SIN;
      plane_distance <= ppp_pkg::RST_PLANE_DIST;
      frame_width    <= ppp_pkg::RST_IMAGE_WIDTH;
      frame_height   <= ppp_pkg::RST_IMAGE_HEIGHT;
    end else if (wr_en) begin
      case (wr_index)
        ppp_pkg::REG_CAMERA_X:     camera_x       <= wr_data;
        ppp_pkg::REG_CAMERA_Y:     camera_y       <= wr_data;
        ppp_pkg::REG_CAMERA_Z:     camera_z       <= wr_data;
        ppp_pkg::REG_YAW_COS:      yaw_cos        <= wr_data[ppp_pkg::TRIG_W-1:0];
        ppp_pkg::REG_YAW_SIN:      yaw_sin        <= wr_data[ppp_pkg::TRIG_W-1:0];
        ppp_pkg::REG_PLANE_DIST:   plane_distance <= wr_data[ppp_pkg::PD_W-1:0];
        ppp_pkg::REG_IMAGE_WIDTH:  frame_width    <= wr_data[ppp_pkg::SIZE_W-1:0];
        ppp_pkg::REG_IMAGE_HEIGHT: frame_height   <= wr_data[ppp_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold plane distance times scale
  always_ff @(posedge clk) begin
    pdk <= ppp_pkg::PDK_W'(plane_distance * frame_height[ppp_pkg::SIZE_W-1:2]);
  end

  logic               in_take, fe_valid, q_valid, q_full;
  ppp_pkg::rot_item_t fe_item, q_item;

  assign busy    = q_full;
  assign in_take = start && !busy;

  ppp_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_take),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .camera_x(camera_x), .camera_y(camera_y), .camera_z(camera_z),
    .yaw_cos(yaw_cos), .yaw_sin(yaw_sin),
    .out_valid(fe_valid), .out_item(fe_item)
  );

  ppp_queue u_queue (
    .clk(clk), .rst(rst), .push(fe_valid), .push_item(fe_item),
    .full(q_full), .out_valid(q_valid), .out_item(q_item)
  );

  ppp_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_item(q_item),
    .pdk(pdk),
    .cen_col(frame_width[ppp_pkg::SIZE_W-1:1]),
    .cen_row(frame_height[ppp_pkg::SIZE_W-1:1]),
    .out_valid(result_valid), .pixel_column(pixel_column),
    .pixel_row(pixel_row), .behind_camera(behind_camera)
  );

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Testbench for the perspective point projector: point requests against an exact predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int FRAC = ppp_pkg::DEF_COORD_FRAC_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [ppp_pkg::PIX_W-1:0] col;
    logic signed [ppp_pkg::PIX_W-1:0] row;
    logic                             behind;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [ppp_pkg::COORD_W-1:0] point_x = '0;
  logic signed [ppp_pkg::COORD_W-1:0] point_y = '0;
  logic signed [ppp_pkg::COORD_W-1:0] point_z = '0;
  logic result_valid;
  logic signed [ppp_pkg::PIX_W-1:0] pixel_column;
  logic signed [ppp_pkg::PIX_W-1:0] pixel_row;
  logic behind_camera;
  logic wr_en = 1'b0;
  logic [ppp_pkg::REG_IDX_W-1:0] wr_index = ppp_pkg::REG_CAMERA_X;
  logic [ppp_pkg::COORD_W-1:0] wr_data = '0;

  // Predictor copy of the camera setup
  logic signed [ppp_pkg::COORD_W-1:0] cam_x, cam_y, cam_z;
  logic signed [ppp_pkg::TRIG_W-1:0] cos_w, sin_w;
  logic [ppp_pkg::PD_W-1:0] plane_dist;
  logic [ppp_pkg::SIZE_W-1:0] img_w, img_h;

  pixel_t pending_pixels[$];
  int errors = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;

  perspective_point_projector dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .result_valid(result_valid), .pixel_column(pixel_column),
    .pixel_row(pixel_row), .behind_camera(behind_camera),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Abort on runaway
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // trunc(num*pd*k/(den*2^F) + center), saturated to 16 bits
  function automatic logic signed [ppp_pkg::PIX_W-1:0] scale_axis(
    logic signed [127:0] num, logic signed [127:0] den, logic signed [127:0] pd,
    logic signed [127:0] k, logic signed [127:0] cen);
    logic signed [127:0] n, d, q;
    d = den <<< FRAC;
    n = num * pd * k + cen * d;
    q = n / d;
    if (q > 32767) return 16'sh7FFF;
    if (q < -32768) return 16'sh8000;
    return q[ppp_pkg::PIX_W-1:0];
  endfunction

  function automatic pixel_t project_point(logic signed [ppp_pkg::COORD_W-1:0] px,
    logic signed [ppp_pkg::COORD_W-1:0] py, logic signed [ppp_pkg::COORD_W-1:0] pz);
    logic signed [127:0] dx, dy, dz, c, s, rx, ry, rz, pd, k;
    pixel_t r;
    dx = px; dx = dx - cam_x;
    dy = py; dy = dy - cam_y;
    dz = pz; dz = dz - cam_z;
    c = cos_w;
    s = sin_w;
    rx = c * dx + s * dy;
    ry = c * dy - s * dx;
    rz = dz <<< ppp_pkg::TRIG_FRAC;
    pd = {97'b0, plane_dist};
    k = {117'b0, img_h[ppp_pkg::SIZE_W-1:2]};
    r.behind = (rx <= 0);
    r.col = '0;
    r.row = '0;
    if (rx != 0) begin
      r.col = scale_axis(ry, rx, pd, k, {116'b0, img_w[ppp_pkg::SIZE_W-1:1]});
      r.row = scale_axis(rz, rx, pd, k, {116'b0, img_h[ppp_pkg::SIZE_W-1:1]});
    end
    return r;
  endfunction

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && result_valid) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result col=%0d row=%0d behind=%0b", $time,
                 pixel_column, pixel_row, behind_camera);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_column !== want.col) begin
          $display("%0t: pixel_column expected %0d actual %0d", $time, want.col,
                   pixel_column);
          errors++;
        end
        if (pixel_row !== want.row) begin
          $display("%0t: pixel_row expected %0d actual %0d", $time, want.row, pixel_row);
          errors++;
        end
        if (behind_camera !== want.behind) begin
          $display("%0t: behind_camera expected %0b actual %0b", $time, want.behind,
                   behind_camera);
          errors++;
        end
      end
    end
  end

  // Hold a point request until accepted, then record its projection
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    bit taken;
    start <= 1'b1;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    pending_pixels.push_back(project_point(px, py, pz));
    if (gaps_on && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drop start and wait out every result
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [ppp_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    case (idx)
      ppp_pkg::REG_CAMERA_X:     cam_x = val;
      ppp_pkg::REG_CAMERA_Y:     cam_y = val;
      ppp_pkg::REG_CAMERA_Z:     cam_z = val;
      ppp_pkg::REG_YAW_COS:      cos_w = val[ppp_pkg::TRIG_W-1:0];
      ppp_pkg::REG_YAW_SIN:      sin_w = val[ppp_pkg::TRIG_W-1:0];
      ppp_pkg::REG_PLANE_DIST:   plane_dist = val[ppp_pkg::PD_W-1:0];
      ppp_pkg::REG_IMAGE_WIDTH:  img_w = val[ppp_pkg::SIZE_W-1:0];
      ppp_pkg::REG_IMAGE_HEIGHT: img_h = val[ppp_pkg::SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
    logic [31:0] c, logic [31:0] s, logic [31:0] pd, logic [31:0] w, logic [31:0] h);
    write_reg(ppp_pkg::REG_CAMERA_X, cx);
    write_reg(ppp_pkg::REG_CAMERA_Y, cy);
    write_reg(ppp_pkg::REG_CAMERA_Z, cz);
    write_reg(ppp_pkg::REG_YAW_COS, c);
    write_reg(ppp_pkg::REG_YAW_SIN, s);
    write_reg(ppp_pkg::REG_PLANE_DIST, pd);
    write_reg(ppp_pkg::REG_IMAGE_WIDTH, w);
    write_reg(ppp_pkg::REG_IMAGE_HEIGHT, h);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Default camera: origin, zero depth, behind, extremes, saturation
  task automatic test_reset_setup;
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000);
    send_point(32'hFFFB_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'hFFF0_0000, 32'h0002_0000, 32'hFFFE_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'hFFFB_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'hFFFA_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_point(32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();
  endtask

  // Register extremes: negative trig, max plane, odd and degenerate sizes
  task automatic test_setup_extremes;
    load_setup(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_C000, 32'h4000,
               32'h7FFF_FFFF, 32'd4096, 32'd4096);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    drain();
    load_setup(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_C000,
               32'h0, 32'd1, 32'd0);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
    load_setup(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h8000, 32'h0000_0001,
               32'd8191, 32'd8191);
    send_point(32'h0001_0000, 32'h0000_1000, 32'h0000_2000);
    send_point(32'hFFFF_0000, 32'hFFFF_F000, 32'h0000_2000);
    send_point(32'h0, 32'h0, 32'h0);
    drain();
  endtask

  function automatic logic [31:0] pick_offset(logic [31:0] base);
    if ($urandom_range(0, 9) < 7)
      return base + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_trig;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 16'hFFFF);
    return $urandom_range(0, 32768) - 16384;
  endfunction

  // Random setups, each followed by a burst of mostly nearby points
  task automatic test_random_points;
    logic [31:0] cx, cy, cz, pd;
    for (int phase = 0; phase < 6; phase++) begin
      cx = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h00A0_0000)
           - 32'h0050_0000;
      cy = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h000A_0000);
      cz = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h000A_0000);
      pd = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 32'h0008_0000);
      load_setup(cx, cy, cz, pick_trig(), pick_trig(), pd, $urandom_range(0, 8191),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                             : $urandom_range(4, 1200));
      gaps_on = (phase != 2);
      for (int n = 0; n < 72; n++) begin
        if (n == 36 && phase == 3) drain();
        send_point(pick_offset(cx), pick_offset(cy), pick_offset(cz));
      end
      drain();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    cam_x = ppp_pkg::RST_CAMERA_X;
    cam_y = ppp_pkg::RST_CAMERA_Y;
    cam_z = ppp_pkg::RST_CAMERA_Z;
    cos_w = ppp_pkg::RST_YAW_COS;
    sin_w = ppp_pkg::RST_YAW_SIN;
    plane_dist = ppp_pkg::RST_PLANE_DIST;
    img_w = ppp_pkg::RST_IMAGE_WIDTH;
    img_h = ppp_pkg::RST_IMAGE_HEIGHT;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_setup();
    test_setup_extremes();
    test_random_points();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
